[sv/qoipe_pkg.sv]
package qoipe_pkg;

    localparam logic [7:0] OP_INDEX = 8'h00;
    localparam logic [7:0] OP_DIFF  = 8'h40;
    localparam logic [7:0] OP_LUMA  = 8'h80;
    localparam logic [7:0] OP_RUN   = 8'hc0;
    localparam logic [7:0] OP_RGB   = 8'hfe;
    localparam logic [7:0] OP_RGBA  = 8'hff;

    // Run count that forces a flush on the next repeat (62 repeats in all)
    localparam logic [5:0] RUN_LAST = 6'd61;

    localparam logic [31:0] PREV_RESET = 32'h0000_00ff;

    localparam int MAX_BYTES = 6;

    // Bytes produced by one pixel, in emission order
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                n;
        logic                      last;
    } qoipe_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qoipe_qstat_t;

endpackage

[sv/qoipe_front.sv]
module qoipe_front
    import qoipe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         alpha_mode,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,
    input  logic         s_tlast,
    input  qoipe_qstat_t q_stat,
    output logic         q_push,
    output qoipe_rec_t   q_wdata
);

    logic [31:0] mem [64];
    logic [63:0] vld_reg, vld_next;

    logic        st_valid_reg;
    logic [31:0] px_reg;
    logic        last_reg;
    logic [5:0]  hash_reg;
    logic [31:0] mem_rd_reg;
    logic        hit_vld_reg;
    logic        fwd_reg;
    logic [31:0] fwd_pix_reg;

    logic [31:0] prev_reg, prev_next;
    logic [5:0]  run_reg, run_next;

    logic [7:0]  in_r, in_g, in_b, in_a;
    logic [5:0]  in_hash;
    logic        accept;
    logic        fire;
    logic        do_write;

    logic [7:0]  r, g, b, a, pr, pg, pb, pa;
    logic        eq, hit;
    logic [31:0] entry;
    logic [7:0]  vr, vg, vb, vgr, vgb;
    logic [7:0]  dr2, dg2, db2, lg32, lr8, lb8;
    logic [4:0][7:0] ob;
    logic [2:0]  on;
    logic [5:0]  run_m1;
    qoipe_rec_t  rec;

    assign in_r = s_tdata[7:0];
    assign in_g = s_tdata[15:8];
    assign in_b = s_tdata[23:16];
    assign in_a = alpha_mode ? s_tdata[31:24] : 8'hff;
    assign in_hash = 6'(in_r[5:0] * 6'd3 + in_g[5:0] * 6'd5 + in_b[5:0] * 6'd7
                        + in_a[5:0] * 6'd11);

    assign fire     = st_valid_reg && !q_stat.full;
    assign s_tready = !st_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    assign {r, g, b, a}     = px_reg;
    assign {pr, pg, pb, pa} = prev_reg;

    assign eq    = (px_reg == prev_reg);
    assign entry = fwd_reg ? fwd_pix_reg : (hit_vld_reg ? mem_rd_reg : 32'h0);
    assign hit   = (entry == px_reg);
    assign do_write = fire && !eq && !hit;

    assign vr  = r - pr;
    assign vg  = g - pg;
    assign vb  = b - pb;
    assign vgr = vr - vg;
    assign vgb = vb - vg;
    assign dr2 = vr + 8'd2;
    assign dg2 = vg + 8'd2;
    assign db2 = vb + 8'd2;
    assign lg32 = vg + 8'd32;
    assign lr8 = vgr + 8'd8;
    assign lb8 = vgb + 8'd8;
    assign run_m1 = run_reg - 6'd1;

    // Main op bytes for a pixel that breaks the run
    always_comb
    begin
        ob = '0;
        on = 3'd0;
        if (hit)
        begin
            ob[0] = OP_INDEX | {2'b00, hash_reg};
            on    = 3'd1;
        end
        else if (alpha_mode && a != pa)
        begin
            ob[0] = OP_RGBA;
            ob[1] = r;
            ob[2] = g;
            ob[3] = b;
            ob[4] = a;
            on    = 3'd5;
        end
        else if (dr2[7:2] == 6'd0 && dg2[7:2] == 6'd0 && db2[7:2] == 6'd0)
        begin
            ob[0] = OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
            on    = 3'd1;
        end
        else if (lg32[7:6] == 2'd0 && lr8[7:4] == 4'd0 && lb8[7:4] == 4'd0)
        begin
            ob[0] = OP_LUMA | {2'b00, lg32[5:0]};
            ob[1] = {lr8[3:0], lb8[3:0]};
            on    = 3'd2;
        end
        else
        begin
            ob[0] = OP_RGB;
            ob[1] = r;
            ob[2] = g;
            ob[3] = b;
            on    = 3'd4;
        end
    end

    always_comb
    begin
        rec      = '0;
        rec.last = last_reg;
        run_next = 6'd0;
        if (eq)
        begin
            if (run_reg == RUN_LAST || last_reg)
            begin
                rec.bytes[0] = OP_RUN | {2'b00, run_reg};
                rec.n        = 3'd1;
            end
            else
            begin
                run_next = run_reg + 6'd1;
            end
        end
        else if (run_reg != 6'd0)
        begin
            rec.bytes = {ob, OP_RUN | {2'b00, run_m1}};
            rec.n     = on + 3'd1;
        end
        else
        begin
            rec.bytes = {8'h00, ob};
            rec.n     = on;
        end
        if (last_reg)
        begin
            run_next = 6'd0;
        end
        prev_next = last_reg ? PREV_RESET : px_reg;
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (do_write)
        begin
            vld_next[hash_reg] = 1'b1;
        end
        if (fire && last_reg)
        begin
            vld_next = '0;
        end
    end

    assign q_push  = fire && (rec.n != 3'd0);
    assign q_wdata = rec;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[hash_reg] <= px_reg;
        end
        if (accept)
        begin
            mem_rd_reg <= mem[in_hash];
        end
    end

    // Stage payload; bypass a same-address write and an end-of-image clear
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg      <= {in_r, in_g, in_b, in_a};
            last_reg    <= s_tlast;
            hash_reg    <= in_hash;
            hit_vld_reg <= vld_reg[in_hash] && !(fire && last_reg);
            fwd_reg     <= do_write && !last_reg && (hash_reg == in_hash);
            fwd_pix_reg <= px_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            vld_reg      <= '0;
            prev_reg     <= PREV_RESET;
            run_reg      <= 6'd0;
        end
        else
        begin
            st_valid_reg <= accept || (st_valid_reg && !fire);
            vld_reg      <= vld_next;
            if (fire)
            begin
                prev_reg <= prev_next;
                run_reg  <= run_next;
            end
        end
    end

endmodule

[sv/qoipe_queue.sv]
module qoipe_queue
    import qoipe_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  qoipe_rec_t   wdata,
    input  logic         pop,
    output qoipe_rec_t   rdata,
    output qoipe_qstat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    qoipe_rec_t    mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign rdata      = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/qoipe_back.sv]
module qoipe_back
    import qoipe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  qoipe_qstat_t q_stat,
    input  qoipe_rec_t   q_rdata,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    qoipe_rec_t  cur_reg;
    logic        cur_valid_reg;
    logic [2:0]  idx_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        item_done_reg;
    logic        m_tlast_reg;

    logic        out_free;
    logic        emit;
    logic        item_end;
    logic        cur_done;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = cur_valid_reg && out_free;
    assign item_end = (idx_reg == cur_reg.n - 3'd1);
    assign cur_done = emit && item_end;
    assign q_pop    = !q_stat.empty && (!cur_valid_reg || cur_done);

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = item_done_reg;
    assign m_tlast    = m_tlast_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_rdata;
        end
        if (emit)
        begin
            m_tdata_reg   <= cur_reg.bytes[idx_reg];
            item_done_reg <= item_end;
            m_tlast_reg   <= item_end && cur_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 3'd0;
            end
            else if (cur_done)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

[sv/qoi_pixel_encoder_top.sv]
// Path: a pixel's first byte passes the classifier stage register, the queue,
// the serializer's current record register and the output byte register.
// Throughput, while m_tready is high: one pixel per cycle if each pixel yields
// at most one byte; otherwise one output byte per cycle, set by the byte serializer.
// The byte queue between classifier and serializer is QUEUE_DEPTH pixels deep.
// Reset: previous pixel opaque black, run zero, color index cleared (valid bits),
// alpha_mode 1; the same image state is restored after every last pixel.
module qoi_pixel_encoder_top
    import qoipe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data,    // alpha_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // red, green, blue, alpha
    input  logic        s_tlast,     // last_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // out_byte
    output logic [0:0]  m_tuser,     // item_done
    output logic        m_tlast      // stream_done
);

    logic         alpha_mode_reg;
    qoipe_qstat_t q_stat;
    logic         q_push;
    logic         q_pop;
    qoipe_rec_t   q_wdata;
    qoipe_rec_t   q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_mode_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            alpha_mode_reg <= cfg_data[0];
        end
    end

    qoipe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .alpha_mode (alpha_mode_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    qoipe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    qoipe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_frame_end_item: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("frame end not on last byte of a pixel");

    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.empty && !q_push) |=> !q_pop)
        else $error("pop without queued record");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
    import qoipe_pkg::*;
;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RUN_MAX       = 62;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

    typedef struct packed {
        logic [7:0] data;
        logic       pixel_end;
        logic       image_end;
    } enc_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // red, green, blue, alpha
    logic        s_tlast = 1'b0;   // last_pixel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // out_byte
    logic [0:0]  m_tuser;          // item_done
    logic        m_tlast;          // stream_done

    // encoder state mirror
    bit          alpha_mode;
    pixel_t      prev_px;
    int          run_len;
    pixel_t      color_idx [64];
    enc_byte_t   exp_bytes [$];

    // stimulus bookkeeping
    pixel_t      last_sent;
    pixel_t      recent_px [$];
    bit          src_gaps = 1'b1;
    bit          sink_gaps = 1'b1;
    logic        sink_hold = 1'b0;
    int          sink_stall = 0;
    int          fail_count = 0;
    int          cycles = 0;

    qoi_pixel_encoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void clear_image();
        prev_px = PREV_RESET;
        run_len = 0;
        foreach (color_idx[i])
            color_idx[i] = '0;
    endfunction

    function automatic logic [7:0] run_op(input int count);
        logic [5:0] code;
        code = 6'(count - 1);
        return OP_RUN | {2'b00, code};
    endfunction

    function automatic void encode_pixel(input pixel_t in_px, input bit is_last);
        pixel_t            px;
        pixel_t            pv;
        logic [7:0]        ops [$];
        logic [31:0]       h;
        logic [5:0]        slot;
        logic signed [7:0] dr, dg, db, dgr, dgb;
        logic [7:0]        ur, ug, ub;
        enc_byte_t         eb;
        px = in_px;
        if (!alpha_mode)
            px.a = 8'hff;
        pv = prev_px;
        if (px == pv)
        begin
            run_len++;
            if (run_len == RUN_MAX)
            begin
                ops.push_back(run_op(run_len));
                run_len = 0;
            end
        end
        else
        begin
            if (run_len > 0)
            begin
                ops.push_back(run_op(run_len));
                run_len = 0;
            end
            h = px.r * 3 + px.g * 5 + px.b * 7 + px.a * 11;
            slot = h[5:0];
            if (color_idx[slot] == px)
                ops.push_back(OP_INDEX | {2'b00, slot});
            else
            begin
                color_idx[slot] = px;
                if (alpha_mode && px.a != pv.a)
                begin
                    ops.push_back(OP_RGBA);
                    ops.push_back(px.r);
                    ops.push_back(px.g);
                    ops.push_back(px.b);
                    ops.push_back(px.a);
                end
                else
                begin
                    // channel deltas wrap at 8 bits
                    dr  = px.r - pv.r;
                    dg  = px.g - pv.g;
                    db  = px.b - pv.b;
                    dgr = dr - dg;
                    dgb = db - dg;
                    if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1)
                    begin
                        ur = 8'(dr + 2);
                        ug = 8'(dg + 2);
                        ub = 8'(db + 2);
                        ops.push_back(OP_DIFF | {2'b00, ur[1:0], ug[1:0], ub[1:0]});
                    end
                    else if (dgr >= -8 && dgr <= 7 && dg >= -32 && dg <= 31 &&
                             dgb >= -8 && dgb <= 7)
                    begin
                        ug = 8'(dg + 32);
                        ur = 8'(dgr + 8);
                        ub = 8'(dgb + 8);
                        ops.push_back(OP_LUMA | {2'b00, ug[5:0]});
                        ops.push_back({ur[3:0], ub[3:0]});
                    end
                    else
                    begin
                        ops.push_back(OP_RGB);
                        ops.push_back(px.r);
                        ops.push_back(px.g);
                        ops.push_back(px.b);
                    end
                end
            end
        end
        prev_px = px;
        if (is_last && run_len > 0)
        begin
            ops.push_back(run_op(run_len));
            run_len = 0;
        end
        foreach (ops[i])
        begin
            eb.data      = ops[i];
            eb.pixel_end = (i == ops.size() - 1);
            eb.image_end = is_last && (i == ops.size() - 1);
            exp_bytes.push_back(eb);
        end
        if (is_last)
            clear_image();
    endfunction

    // output side: random stalls, plus a long hold while sink_hold is set
    always @(posedge clk)
    begin
        if (sink_hold)
            m_tready <= 1'b0;
        else if (sink_stall > 0)
        begin
            m_tready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else if (sink_gaps && $urandom_range(0, 9) == 0)
        begin
            m_tready <= 1'b0;
            sink_stall <= $urandom_range(0, 17);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : byte_check
        enc_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exp_bytes.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected word: data %02h item_done %0b stream_done %0b",
                             m_tdata, m_tuser, m_tlast);
                fail_count++;
            end
            else
            begin
                want = exp_bytes.pop_front();
                if (m_tdata !== want.data || m_tuser !== want.pixel_end ||
                    m_tlast !== want.image_end)
                begin
                    if (fail_count < 10)
                        $display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                 want.data, want.pixel_end, want.image_end,
                                 m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_pixel(input pixel_t px, input bit is_last);
        int gap;
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {px.a, px.b, px.g, px.r};
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // valid stays high; the next call or wait_idle decides
        last_sent = px;
        recent_px.push_back(px);
        if (recent_px.size() > 32)
            void'(recent_px.pop_front());
        encode_pixel(px, is_last);
    endtask

    task automatic send_rgba(input logic [7:0] r, g, b, a, input bit is_last = 1'b0);
        send_pixel({r, g, b, a}, is_last);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (exp_bytes.size() != 0)
            @(posedge clk);
        // a run pixel may still be in flight with nothing expected
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input bit mode);
        wait_idle();
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        alpha_mode = mode;
    endtask

    task automatic test_directed();
        write_mode(1'b1);
        send_rgba(8'd0, 8'd0, 8'd0, 8'd255);       // equals reset pixel: run
        send_rgba(8'd0, 8'd0, 8'd0, 8'd255);
        send_rgba(8'd0, 8'd0, 8'd0, 8'd0);         // flush run, hit cleared slot 0
        send_rgba(8'd1, 8'd1, 8'd1, 8'd0);         // diff +1
        send_rgba(8'd255, 8'd255, 8'd255, 8'd0);   // diff -2 with wrap
        send_rgba(8'd10, 8'd5, 8'd10, 8'd0);       // luma
        send_rgba(8'd200, 8'd50, 8'd100, 8'd0);    // rgb
        send_rgba(8'd200, 8'd50, 8'd100, 8'd128);  // rgba
        send_rgba(8'd255, 8'd255, 8'd255, 8'd255);
        send_rgba(8'd10, 8'd5, 8'd10, 8'd0);       // index hit
        send_rgba(8'd48, 8'd36, 8'd33, 8'd0);      // luma at edges: dg 31, dr-dg 7, db-dg -8
        send_rgba(8'd8, 8'd4, 8'd8, 8'd0);         // luma at edges: dg -32, dr-dg -8, db-dg 7
        send_rgba(8'd9, 8'd5, 8'd9, 8'd0);         // diff +1 on all channels
        send_rgba(8'd9, 8'd5, 8'd9, 8'd0);
        send_rgba(8'd9, 8'd5, 8'd9, 8'd0);
        send_rgba(8'd9, 8'd5, 8'd9, 8'd0, 1'b1);   // end of image flushes run
        send_rgba(8'd0, 8'd0, 8'd0, 8'd255);       // fresh image state
        send_rgba(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
        send_rgba(8'd255, 8'd0, 8'd128, 8'd7, 1'b1);
        send_rgba(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    endtask

    task automatic test_run_limit();
        send_rgba(8'd77, 8'd77, 8'd77, 8'd255);
        repeat (130) send_rgba(8'd77, 8'd77, 8'd77, 8'd255);
        send_rgba(8'd78, 8'd77, 8'd77, 8'd255, 1'b1);
        // run reaching its limit exactly on the last pixel
        send_rgba(8'd3, 8'd200, 8'd9, 8'd255);
        repeat (61) send_rgba(8'd3, 8'd200, 8'd9, 8'd255);
        send_rgba(8'd3, 8'd200, 8'd9, 8'd255, 1'b1);
    endtask

    task automatic test_mode_switch();
        write_mode(1'b1);
        send_rgba(8'd20, 8'd30, 8'd40, 8'd10);
        send_rgba(8'd21, 8'd30, 8'd40, 8'd10);
        // switch inside the image: alpha difference is dropped
        write_mode(1'b0);
        send_rgba(8'd22, 8'd31, 8'd39, 8'd10);
        send_rgba(8'd40, 8'd50, 8'd60, 8'd0);
        send_rgba(8'd140, 8'd7, 8'd250, 8'hff);
        send_rgba(8'd140, 8'd7, 8'd250, 8'h55);    // alpha ignored: run
        send_rgba(8'd0, 8'd0, 8'd0, 8'd0);         // alpha taken as opaque
        send_rgba(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_rgba(8'd0, 8'd0, 8'd0, 8'd33, 1'b1);  // lone pixel equal to reset pixel
    endtask

    task automatic test_pressure();
        write_mode(1'b1);
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold <= 1'b0;
            end
            begin
                // alpha changes every pixel: five-byte ops back up the queue
                for (int i = 0; i < 40; i++)
                    send_rgba(8'($urandom), 8'($urandom), 8'($urandom), 8'(i), i == 39);
            end
        join
    endtask

    function automatic pixel_t next_pixel();
        pixel_t p;
        int     dg;
        p = last_sent;
        case ($urandom_range(0, 11)) inside
            [0:1]: ;                                  // repeat: extend run
            2:
            begin
                p.r = 8'(p.r + $urandom_range(0, 4) - 2);
                p.g = 8'(p.g + $urandom_range(0, 4) - 2);
                p.b = 8'(p.b + $urandom_range(0, 4) - 2);
            end
            [3:4]:
            begin
                dg  = $urandom_range(0, 64) - 32;
                p.g = 8'(p.g + dg);
                p.r = 8'(p.r + dg + $urandom_range(0, 16) - 8);
                p.b = 8'(p.b + dg + $urandom_range(0, 16) - 8);
            end
            [5:6]:
                if (recent_px.size() > 0)
                    p = recent_px[$urandom_range(0, recent_px.size() - 1)];
            7:
                p.a = 8'($urandom);
            8:
                p.r = 8'($urandom);
            9:
            begin
                p.r = $urandom_range(0, 1) ? 8'hff : 8'h00;
                p.g = $urandom_range(0, 1) ? 8'hff : 8'h00;
                p.b = $urandom_range(0, 1) ? 8'hff : 8'h00;
                p.a = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            default:
                p = $urandom;
        endcase
        return p;
    endfunction

    task automatic test_random(input bit mode, input int count);
        pixel_t p;
        write_mode(mode);
        for (int i = 0; i < count; i++)
        begin
            p = next_pixel();
            send_pixel(p, $urandom_range(0, 29) == 0);
        end
    endtask

    initial
    begin
        alpha_mode = 1'b1;
        clear_image();
        last_sent = PREV_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_run_limit();
        test_mode_switch();
        test_pressure();
        test_random(1'b1, 40);
        test_random(1'b0, 30);
        test_random(1'b1, 30);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        test_random(1'b0, 30);
        wait_idle();
        if (fail_count == 0 && exp_bytes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[qoi_pixel_encoder_top.f]
sv/qoipe_pkg.sv
sv/qoipe_front.sv
sv/qoipe_queue.sv
sv/qoipe_back.sv
sv/qoi_pixel_encoder_top.sv
dv/tb_top.sv
